/* rtl/imadec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imadec_pkg
// shared types, constants and tables of the ima adpcm nibble decoder
// ----------------------------------------------------------------------------
package imadec_pkg;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [6:0] IDX_MAX = 7'd88;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  localparam logic signed [17:0] POS_LIMIT = 18'sd32767;
  localparam logic signed [17:0] NEG_LIMIT = -18'sd32767;

  typedef enum logic {
    PH_LOW,
    PH_HIGH
  } phase_t;

  // classified input transaction
  typedef struct packed {
    logic               is_hdr;
    logic signed [15:0] sample;
    logic [6:0]         idx;
    logic [7:0]         code_byte;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic signed [15:0] pcm;
    logic               last;
  } res_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // signed index step for the low three code bits
  function automatic logic signed [4:0] index_move(input logic [2:0] c);
    logic signed [4:0] m;
    case (c)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

/* rtl/ima_adpcm_nibble_decoder.sv */
`timescale 1ns / 1ps
// the first sample of a transaction reaches pcm_sample through the command and result queues,
// the second sample of a data byte is the high nibble, decoded once the low nibble is done
// a header gives one sample and a data byte two, one nibble per cycle while the result queue has room
// the rate is set by the nibble datapath, whose predictor and step index feed back each cycle
// reset: synchronous rst clears both queues, the predictor and the step index to zero
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder
// 4-bit ima adpcm decoder with header load, saturating predictor and index
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder #(
  parameter int CMD_DEPTH = imadec_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = imadec_pkg::RES_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // input transaction queue side
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic signed [15:0] initial_sample,
  input  logic [6:0]         initial_step_index,
  input  logic [7:0]         code_byte,
  // result transaction queue side
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] pcm_sample,
  output logic               last_of_run
);

  // command link between the front and the back
  imadec_pkg::cmd_t cmd;
  logic             cmd_empty;
  logic             cmd_pop;

  // front: classify the transaction (header or data), saturate the header
  // index and hold it in a short command queue
  imadec_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .req_type           (req_type),
    .initial_sample     (initial_sample),
    .initial_step_index (initial_step_index),
    .code_byte          (code_byte),
    .cmd                (cmd),
    .cmd_empty          (cmd_empty),
    .cmd_pop            (cmd_pop)
  );

  // back: header echo or one nibble per cycle while the result queue has room, low
  // nibble first; samples go to a result queue so input and output stall independently
  imadec_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .pcm_sample  (pcm_sample),
    .last_of_run (last_of_run)
  );

endmodule

/* rtl/imadec_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imadec_fifo
// small register queue with first-word fall-through read
// ----------------------------------------------------------------------------
module imadec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

/* rtl/imadec_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imadec_front
// accepts input transactions, classifies them and queues commands
// ----------------------------------------------------------------------------
module imadec_front #(
  parameter int CMD_DEPTH = imadec_pkg::CMD_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                req_type,
  input  logic signed [15:0]  initial_sample,
  input  logic [6:0]          initial_step_index,
  input  logic [7:0]          code_byte,
  output imadec_pkg::cmd_t    cmd,
  output logic                cmd_empty,
  input  logic                cmd_pop
);

  localparam int CMD_W = $bits(imadec_pkg::cmd_t);

  imadec_pkg::cmd_t cmd_in;
  logic [CMD_W-1:0] cmd_raw;

  // header index above the table end saturates to the last entry
  always_comb begin
    cmd_in.is_hdr    = (req_type == imadec_pkg::REQ_HEADER);
    cmd_in.sample    = initial_sample;
    cmd_in.idx       = (initial_step_index > imadec_pkg::IDX_MAX) ?
                       imadec_pkg::IDX_MAX : initial_step_index;
    cmd_in.code_byte = code_byte;
  end

  imadec_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_raw),
    .empty   (cmd_empty)
  );

  assign cmd = imadec_pkg::cmd_t'(cmd_raw);

endmodule

/* rtl/imadec_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imadec_back
// echoes headers and decodes one nibble per cycle while the result queue has room, queuing the samples
// ----------------------------------------------------------------------------
module imadec_back #(
  parameter int RES_DEPTH = imadec_pkg::RES_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  imadec_pkg::cmd_t    cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output logic signed [15:0]  pcm_sample,
  output logic                last_of_run
);

  localparam int RES_W = $bits(imadec_pkg::res_t);

  imadec_pkg::phase_t phase;
  imadec_pkg::phase_t phase_next;
  logic signed [15:0] predictor;
  logic signed [15:0] predictor_next;
  logic [6:0]         step_pos;
  logic [6:0]         step_pos_next;

  logic               res_full;
  logic               go;
  logic [3:0]         nib;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [17:0] clip;
  logic signed [8:0]  ni;
  logic signed [4:0]  move;
  imadec_pkg::res_t   res_in;
  imadec_pkg::res_t   res_out;
  logic [RES_W-1:0]   res_raw;

  assign go  = !cmd_empty && !res_full;
  assign nib = (phase == imadec_pkg::PH_LOW) ? cmd.code_byte[3:0] : cmd.code_byte[7:4];

  // nibble datapath
  always_comb begin
    step = imadec_pkg::step_size(step_pos);
    diff = {5'd0, step[14:3]}
         + (nib[0] ? {4'd0, step[14:2]} : 17'd0)
         + (nib[1] ? {3'd0, step[14:1]} : 17'd0)
         + (nib[2] ? {2'd0, step}       : 17'd0);
    if (nib[3]) begin
      sum  = 18'(predictor) - $signed({1'b0, diff});
      clip = (sum < imadec_pkg::NEG_LIMIT) ? imadec_pkg::NEG_LIMIT : sum;
    end else begin
      sum  = 18'(predictor) + $signed({1'b0, diff});
      clip = (sum > imadec_pkg::POS_LIMIT) ? imadec_pkg::POS_LIMIT : sum;
    end
    move = imadec_pkg::index_move(nib[2:0]);
    ni   = $signed({2'b00, step_pos}) + $signed({{4{move[4]}}, move});
  end

  // sequencer
  always_comb begin
    phase_next     = phase;
    predictor_next = predictor;
    step_pos_next  = step_pos;
    cmd_pop        = 1'b0;
    res_in.pcm     = clip[15:0];
    res_in.last    = (phase == imadec_pkg::PH_HIGH);
    if (cmd.is_hdr) begin
      res_in.pcm  = cmd.sample;
      res_in.last = 1'b1;
    end
    if (go) begin
      if (cmd.is_hdr) begin
        predictor_next = cmd.sample;
        step_pos_next  = cmd.idx;
        cmd_pop        = 1'b1;
        phase_next     = imadec_pkg::PH_LOW;
      end else begin
        predictor_next = clip[15:0];
        if (ni < 9'sd0) begin
          step_pos_next = 7'd0;
        end else if (ni > $signed({2'b00, imadec_pkg::IDX_MAX})) begin
          step_pos_next = imadec_pkg::IDX_MAX;
        end else begin
          step_pos_next = ni[6:0];
        end
        case (phase)
          imadec_pkg::PH_LOW: begin
            phase_next = imadec_pkg::PH_HIGH;
          end
          imadec_pkg::PH_HIGH: begin
            phase_next = imadec_pkg::PH_LOW;
            cmd_pop    = 1'b1;
          end
          default: begin
            phase_next = imadec_pkg::PH_LOW;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= imadec_pkg::PH_LOW;
      predictor <= '0;
      step_pos  <= '0;
    end else begin
      phase     <= phase_next;
      predictor <= predictor_next;
      step_pos  <= step_pos_next;
    end
  end

  imadec_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (go),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_raw),
    .empty   (empty)
  );

  assign res_out     = imadec_pkg::res_t'(res_raw);
  assign pcm_sample  = res_out.pcm;
  assign last_of_run = res_out.last;

`ifndef SYNTHESIS
  a_step_range : assert property (@(posedge clk) disable iff (rst)
    step_pos <= imadec_pkg::IDX_MAX)
    else $error("step index beyond table end");

  a_high_has_data : assert property (@(posedge clk) disable iff (rst)
    (phase == imadec_pkg::PH_HIGH) |-> (!cmd_empty && !cmd.is_hdr))
    else $error("second nibble without a pending data command");

  a_low_then_high : assert property (@(posedge clk) disable iff (rst)
    (go && !res_in.last) |=> (phase == imadec_pkg::PH_HIGH))
    else $error("first nibble not followed by second nibble phase");

  a_pop_on_last : assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (go && res_in.last))
    else $error("command released before its last sample");
`endif

endmodule

/* tb/ima_adpcm_nibble_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder_tb
// self-checking bench: headers and code bytes go into the input queue, every
// decoded sample that comes out is compared with a behavioral decoder
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 335;
  localparam int MAX_REPORTS = 10;

  // one input transaction as the driver presents it
  typedef struct packed {
    logic               kind;
    logic signed [15:0] start_sample;
    logic [6:0]         start_index;
    logic [7:0]         codes;
  } adpcm_item_t;

  // one decoded sample as the decoder should emit it
  typedef struct packed {
    logic signed [15:0] pcm;
    logic               last;
  } pcm_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               req_type = imadec_pkg::REQ_HEADER;
  logic signed [15:0] initial_sample = '0;
  logic [6:0]         initial_step_index = '0;
  logic [7:0]         code_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] pcm_sample;
  logic               last_of_run;

  adpcm_item_t pending_items[$];
  pcm_beat_t   expected_samples[$];

  // behavioral decoder state
  int dec_predictor = 0;
  int dec_step_pos = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // standard ima step sizes, index 0..88
  const int step_lut[89] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31,
    34, 37, 41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143,
    157, 173, 190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
    724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272, 2499,
    2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132, 7845, 8630,
    9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500, 20350, 22385, 24623,
    27086, 29794, 32767
  };

  ima_adpcm_nibble_decoder DUT (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .req_type           (req_type),
    .initial_sample     (initial_sample),
    .initial_step_index (initial_step_index),
    .code_byte          (code_byte),
    .empty              (empty),
    .pop                (pop),
    .pcm_sample         (pcm_sample),
    .last_of_run        (last_of_run)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one nibble through the decoder: diff from truncated step fractions,
  // clipped to +-32767, index moved by the code magnitude and clamped 0..88
  function automatic logic signed [15:0] decode_nibble(input logic [3:0] code);
    int step;
    int diff;
    int nxt;
    int nidx;
    step = step_lut[dec_step_pos];
    diff = step / 8;
    if (code[0]) diff += step / 4;
    if (code[1]) diff += step / 2;
    if (code[2]) diff += step;
    if (!code[3]) begin
      nxt = dec_predictor + diff;
      if (nxt > 32767) nxt = 32767;
    end else begin
      nxt = dec_predictor - diff;
      // only a negative code clips at the bottom, so -32768 can survive
      if (nxt < -32767) nxt = -32767;
    end
    dec_predictor = nxt;
    nidx = code[2] ? dec_step_pos + 2 * (int'(code[1:0]) + 1) : dec_step_pos - 1;
    if (nidx < 0) nidx = 0;
    if (nidx > 88) nidx = 88;
    dec_step_pos = nidx;
    return nxt[15:0];
  endfunction

  // append at the tail of the expected sample queue
  task automatic add_expected(input pcm_beat_t b);
    expected_samples.insert(expected_samples.size(), b);
  endtask

  // append at the tail of the pending transaction queue
  task automatic add_pending(input adpcm_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // expected samples for one accepted transaction
  task automatic predict_samples(input adpcm_item_t it);
    pcm_beat_t b;
    if (it.kind == imadec_pkg::REQ_HEADER) begin
      dec_predictor = it.start_sample;
      dec_step_pos = (it.start_index > 7'd88) ? 88 : int'(it.start_index);
      b.pcm = it.start_sample;
      b.last = 1'b1;
      add_expected(b);
    end else begin
      // low nibble first
      b.pcm = decode_nibble(it.codes[3:0]);
      b.last = 1'b0;
      add_expected(b);
      b.pcm = decode_nibble(it.codes[7:4]);
      b.last = 1'b1;
      add_expected(b);
    end
  endtask

  // header with random don't-care code byte
  task automatic queue_header(input logic signed [15:0] s, input logic [6:0] idx);
    adpcm_item_t it;
    it.kind = imadec_pkg::REQ_HEADER;
    it.start_sample = s;
    it.start_index = idx;
    it.codes = 8'($urandom);
    add_pending(it);
  endtask

  // code byte with random don't-care header fields
  task automatic queue_codes(input logic [7:0] codes);
    adpcm_item_t it;
    it.kind = imadec_pkg::REQ_DATA;
    it.start_sample = 16'($urandom);
    it.start_index = 7'($urandom);
    it.codes = codes;
    add_pending(it);
  endtask

  // hold the sender until every transaction is in and every sample is out
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_samples.size() != 0) @(posedge clk);
  endtask

  // random stream: mostly code bytes with the odd header, some runs of
  // extreme codes to push the predictor into both clip limits
  task automatic queue_random(input int count);
    int k;
    logic [7:0] run_byte;
    int run_left;
    run_left = 0;
    run_byte = 8'h00;
    for (k = 0; k < count; k++) begin
      if (run_left > 0) begin
        queue_codes(run_byte);
        run_left--;
      end else if ($urandom_range(11) == 0) begin
        case ($urandom_range(5))
          0: queue_header(16'sh7FFF, 7'($urandom_range(88)));
          1: queue_header(-16'sh8000, 7'($urandom_range(88)));
          2: queue_header(16'($urandom), 7'($urandom_range(127, 89)));
          default: queue_header(16'($urandom), 7'($urandom_range(88)));
        endcase
      end else if ($urandom_range(9) == 0) begin
        case ($urandom_range(5))
          0: run_byte = 8'h77;
          1: run_byte = 8'hFF;
          2: run_byte = 8'h00;
          3: run_byte = 8'h88;
          4: run_byte = 8'h7F;
          default: run_byte = 8'hF7;
        endcase
        run_left = $urandom_range(12, 3);
        queue_codes(run_byte);
      end else begin
        queue_codes(8'($urandom));
      end
    end
  endtask

  // driver: present the oldest pending transaction on the falling edge
  always @(negedge clk) begin
    if (!rst && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      push               <= 1'b1;
      req_type           <= pending_items[0].kind;
      initial_sample     <= pending_items[0].start_sample;
      initial_step_index <= pending_items[0].start_index;
      code_byte          <= pending_items[0].codes;
    end else begin
      push <= 1'b0;
    end
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: input acceptance feeds the decoder model, results are checked
  always @(posedge clk) begin
    pcm_beat_t want;
    if (!rst) begin
      if (push && !full) begin
        predict_samples(pending_items[0]);
        void'(pending_items.pop_front());
      end
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected sample: pcm %0d last %0b", pcm_sample, last_of_run);
        end else begin
          want = expected_samples.pop_front();
          if (pcm_sample !== want.pcm || last_of_run !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("sample mismatch: pcm exp %0d got %0d, last exp %0b got %0b",
                       want.pcm, pcm_sample, want.last, last_of_run);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every code in at least one nibble position, clip corners
    queue_header(16'sh0000, 7'd0);
    queue_codes(8'h00);
    queue_codes(8'hFF);
    queue_codes(8'h10);
    queue_codes(8'h32);
    queue_codes(8'h54);
    queue_codes(8'h76);
    queue_codes(8'h98);
    queue_codes(8'hBA);
    queue_codes(8'hDC);
    queue_codes(8'hFE);
    queue_header(16'sh7FFF, 7'd88);
    queue_codes(8'h77);
    // index above the table end saturates
    queue_header(-16'sh8000, 7'd127);
    queue_codes(8'hFF);
    // -32768 kept by a zero positive diff, clipped by a negative code
    queue_header(-16'sh8000, 7'd0);
    queue_codes(8'h80);
    queue_header(-16'sh8000, 7'd0);
    queue_codes(8'h09);
    queue_header(16'sh5555, 7'h55);
    queue_codes(8'hAA);
    queue_codes(8'h55);
    queue_header(-16'sh5556, 7'h2A);
    queue_codes(8'h7F);
    wait_drained();

    // no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(ITEMS_PER_PHASE / 2);
    // sender holds off until the decoder has emptied out
    wait_drained();
    queue_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
    wait_drained();

    // sender mostly idle
    send_idle_pct = 67;
    recv_stall_pct = 0;
    queue_random(ITEMS_PER_PHASE);
    wait_drained();

    // receiver mostly stalling
    send_idle_pct = 0;
    recv_stall_pct = 67;
    queue_random(ITEMS_PER_PHASE);
    wait_drained();

    // both sides irregular
    send_idle_pct = 34;
    recv_stall_pct = 34;
    queue_random(ITEMS_PER_PHASE);
    wait_drained();

    // let any stray samples surface
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/imadec_pkg.sv
rtl/imadec_fifo.sv
rtl/imadec_front.sv
rtl/imadec_back.sv
rtl/ima_adpcm_nibble_decoder.sv
tb/ima_adpcm_nibble_decoder_tb.sv
